// ===== design/lemd_pkg.sv =====
package lemd_pkg;

  // line buffer and channel geometry
  localparam int MAX_LINE     = 1024;
  localparam int CHANNEL_BITS = 16;

  localparam int COL_W  = $clog2(MAX_LINE);
  localparam int LEN_W  = $clog2(MAX_LINE + 1);
  localparam int ROW_W  = 17;
  localparam int ROW_SW = ROW_W + 1;
  localparam int SUM_W  = (CHANNEL_BITS + 3 > 18) ? CHANNEL_BITS + 3 : 18;

  // field widths of the ports
  localparam int IN_CH_W    = 16;
  localparam int THR_W      = 16;
  localparam int LLEN_W     = 11;
  localparam int LCNT_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1) + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 2'd2;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef chan_t [2:0] pix_t;
  typedef pix_t [1:0] pix_pair_t;

  // where the stencil centre sits in the frame
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } pos_t;

  // facts about the result pixel of a step
  typedef struct packed {
    logic ok;
    logic border;
    logic last;
  } qinfo_t;

endpackage

// ===== design/laplacian_edge_mask_dilate.sv =====
// channel | handshake              | payload
// --------+------------------------+-------------------------------------
// in      | in_valid_i/in_ready_o  | red_i, green_i, blue_i, filler_i
// out     | out_valid_o/out_ready_i| edge_res_o, frame_last_o
// cfg     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// one pixel per clock while ready; a result is offered after the transaction
// that completes its neighbourhood, 2*line_length+2 pixels after its own
// the rate is set by the single read and write port of each line memory
// reset clears counters, valid bits and the result queue; no clearing pass
// queue entries are reserved for every step in flight, so in_ready_o drops
// once the queue and the five pipeline stages hold eight between them
module laplacian_edge_mask_dilate
  import lemd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IN_CH_W-1:0]    red_i,
  input  logic [IN_CH_W-1:0]    green_i,
  input  logic [IN_CH_W-1:0]    blue_i,
  input  logic                  filler_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  edge_res_o,
  output logic                  frame_last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration
  logic [THR_W-1:0]  thr_q;
  logic [LLEN_W-1:0] llen_q;
  logic [LCNT_W-1:0] lcnt_q;

  // clamped frame geometry
  logic [LEN_W-1:0]  len;
  logic [LCNT_W-1:0] lines;
  logic [LCNT_W-1:0] n_row;
  logic [COL_W-1:0]  last_col;

  always_comb begin
    if (llen_q < LLEN_W'(3)) begin
      len = LEN_W'(3);
    end else if (32'(llen_q) > 32'(MAX_LINE)) begin
      len = LEN_W'(MAX_LINE);
    end else begin
      len = LEN_W'(llen_q);
    end
    lines    = (lcnt_q < LCNT_W'(3)) ? LCNT_W'(3) : lcnt_q;
    n_row    = lines - LCNT_W'(1);
    last_col = COL_W'(len - LEN_W'(1));
  end

  // position of the newest pixel of the stream (row, column)
  logic [COL_W-1:0] ci_q, ci_d;
  logic [ROW_W-1:0] ri_q, ri_d;

  logic signed [ROW_SW-1:0] ri_s, n_s, erow, qrow;
  logic [COL_W-1:0]         ecol, qcol;
  logic                     ci_lt2;
  pos_t                     epos;
  qinfo_t                   qinfo;
  logic                     drain, accept, step, cfg_hit;

  // centre of the first-stage stencil is line_length+1 pixels back,
  // centre of the widening window 2*line_length+2 pixels back
  always_comb begin
    ri_s   = $signed({1'b0, ri_q});
    n_s    = $signed({{(ROW_SW-LCNT_W){1'b0}}, n_row});
    ci_lt2 = (ci_q < COL_W'(2));
    if (ci_q == '0) begin
      erow = ri_s - $signed(ROW_SW'(2));
      ecol = last_col;
    end else begin
      erow = ri_s - $signed(ROW_SW'(1));
      ecol = ci_q - COL_W'(1);
    end
    if (ci_lt2) begin
      qrow = ri_s - $signed(ROW_SW'(3));
      qcol = COL_W'(LEN_W'(ci_q) + len - LEN_W'(2));
    end else begin
      qrow = ri_s - $signed(ROW_SW'(2));
      qcol = ci_q - COL_W'(2);
    end
    epos.top     = (erow == '0);
    epos.bot     = (erow == n_s);
    epos.lft     = (ecol == '0);
    epos.rgt     = (ecol == last_col);
    qinfo.ok     = !qrow[ROW_SW-1];
    qinfo.border = (qrow == '0) || (qrow == n_s) || (qcol == '0) || (qcol == last_col);
    qinfo.last   = qinfo.ok && (qrow == n_s) && (qcol == last_col);
  end

  // once all pixels are in, every transaction drains one step
  assign drain   = (ri_q >= {1'b0, lines});
  assign accept  = in_valid_i && in_ready_o;
  assign step    = accept && (drain || !filler_i);
  assign cfg_hit = cfg_we_i && ((cfg_index_i == REG_EDGE_THRESHOLD) ||
                                (cfg_index_i == REG_LINE_LENGTH) ||
                                (cfg_index_i == REG_LINE_COUNT));

  always_comb begin
    ci_d = ci_q;
    ri_d = ri_q;
    if (cfg_hit) begin
      ci_d = '0;
      ri_d = '0;
    end else if (step) begin
      if (qinfo.last) begin
        // frame done, the next real pixel opens a new one
        ci_d = '0;
        ri_d = '0;
      end else if (ci_q == last_col) begin
        ci_d = '0;
        ri_d = ri_q + ROW_W'(1);
      end else begin
        ci_d = ci_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_W'(205);
      llen_q <= LLEN_W'(1024);
      lcnt_q <= LCNT_W'(1024);
      ci_q   <= '0;
      ri_q   <= '0;
    end else begin
      ci_q <= ci_d;
      ri_q <= ri_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_EDGE_THRESHOLD: thr_q  <= cfg_wdata_i[THR_W-1:0];
          REG_LINE_LENGTH:    llen_q <= cfg_wdata_i[LLEN_W-1:0];
          REG_LINE_COUNT:     lcnt_q <= cfg_wdata_i[LCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: pixel line memory, entry holds the two lines above a column
  // read at acceptance, written back in the following cycle; a column comes round
  // again only after line_length >= 3 steps, so no forwarding is needed
  // ---------------------------------------------------------------------
  pix_pair_t pix_mem [MAX_LINE];
  pix_pair_t pix_rd_q;
  pix_t      s1_pix_q;
  logic [COL_W-1:0] s1_col_q, s1_ecol_q;
  pos_t      s1_epos_q;
  qinfo_t    s1_qinfo_q;
  logic      s1_v_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      pix_rd_q   <= pix_mem[ci_q];
      s1_pix_q   <= {chan_t'(red_i), chan_t'(green_i), chan_t'(blue_i)};
      s1_col_q   <= ci_q;
      s1_ecol_q  <= ecol;
      s1_epos_q  <= epos;
      s1_qinfo_q <= qinfo;
    end
    if (s1_v_q) begin
      pix_mem[s1_col_q] <= {pix_rd_q[0], s1_pix_q};
    end
  end

  // 3x3 pixel window, only the taps the stencils use
  pix_t bot0_q, bot1_q, mid0_q, mid1_q, mid2_q, top0_q, top1_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      bot0_q <= s1_pix_q;
      bot1_q <= bot0_q;
      mid0_q <= pix_rd_q[0];
      mid1_q <= mid0_q;
      mid2_q <= mid1_q;
      top0_q <= pix_rd_q[1];
      top1_q <= top0_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: per-channel laplacian
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] s2_ecol_q;
  pos_t             s2_epos_q;
  qinfo_t           s2_qinfo_q;
  logic             s2_v_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_ecol_q  <= s1_ecol_q;
      s2_epos_q  <= s1_epos_q;
      s2_qinfo_q <= s1_qinfo_q;
    end
  end

  logic signed [SUM_W-1:0] lap [3];
  logic                    interior;

  always_comb begin
    logic corner, hline;
    chan_t n1, n2, n3, n4, ctr;
    corner   = (s2_epos_q.top || s2_epos_q.bot) && (s2_epos_q.lft || s2_epos_q.rgt);
    hline    = s2_epos_q.top || s2_epos_q.bot;
    interior = !(s2_epos_q.top || s2_epos_q.bot || s2_epos_q.lft || s2_epos_q.rgt);
    for (int ch = 0; ch < 3; ch++) begin
      ctr = mid1_q[ch];
      if (corner) begin
        // horizontal neighbour inside the line, vertical one inside the frame
        n1 = s2_epos_q.lft ? mid0_q[ch] : mid2_q[ch];
        n2 = s2_epos_q.top ? bot1_q[ch] : top1_q[ch];
      end else if (hline) begin
        n1 = mid2_q[ch];
        n2 = mid0_q[ch];
      end else begin
        n1 = top1_q[ch];
        n2 = bot1_q[ch];
      end
      n3 = interior ? mid2_q[ch] : '0;
      n4 = interior ? mid0_q[ch] : '0;
      lap[ch] = $signed(SUM_W'(n1)) + $signed(SUM_W'(n2)) + $signed(SUM_W'(n3))
              + $signed(SUM_W'(n4))
              - (interior ? $signed(SUM_W'(ctr) << 2) : $signed(SUM_W'(ctr) << 1));
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: threshold, doubled for interior pixels
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] s3_lap_q [3];
  logic             s3_int_q;
  logic [COL_W-1:0] s3_ecol_q;
  qinfo_t           s3_qinfo_q;
  logic             s3_v_q;

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      s3_lap_q   <= lap;
      s3_int_q   <= interior;
      s3_ecol_q  <= s2_ecol_q;
      s3_qinfo_q <= s2_qinfo_q;
    end
  end

  logic signed [SUM_W-1:0] thr_ext;
  logic                    ebit;

  always_comb begin
    thr_ext = s3_int_q ? $signed(SUM_W'({thr_q, 1'b0})) : $signed(SUM_W'(thr_q));
    // the largest channel is above the threshold when any one is
    ebit = (s3_lap_q[0] > thr_ext) || (s3_lap_q[1] > thr_ext) || (s3_lap_q[2] > thr_ext);
  end

  // ---------------------------------------------------------------------
  // stage 4: edge line memory, two mask lines per column
  // ---------------------------------------------------------------------
  logic [1:0]       edge_mem [MAX_LINE];
  logic [1:0]       edge_rd_q;
  logic             s4_ebit_q;
  logic [COL_W-1:0] s4_ecol_q;
  qinfo_t           s4_qinfo_q;
  logic             s4_v_q;

  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      edge_rd_q  <= edge_mem[s3_ecol_q];
      s4_ebit_q  <= ebit;
      s4_ecol_q  <= s3_ecol_q;
      s4_qinfo_q <= s3_qinfo_q;
    end
    if (s4_v_q) begin
      edge_mem[s4_ecol_q] <= {edge_rd_q[0], s4_ebit_q};
    end
  end

  // 3x3 mask window
  logic [2:0] ebot_q, emid_q, etop_q;
  qinfo_t     s5_qinfo_q;
  logic       s5_v_q;

  always_ff @(posedge clk_i) begin
    if (s4_v_q) begin
      ebot_q     <= {ebot_q[1:0], s4_ebit_q};
      emid_q     <= {emid_q[1:0], edge_rd_q[0]};
      etop_q     <= {etop_q[1:0], edge_rd_q[1]};
      s5_qinfo_q <= s4_qinfo_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: widening, border pixels keep their own mark
  // ---------------------------------------------------------------------
  logic wide, push, pop;

  assign wide = s5_qinfo_q.border ? emid_q[1] : (|ebot_q) || (|emid_q) || (|etop_q);
  assign push = s5_v_q && s5_qinfo_q.ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      s1_v_q <= step;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  // result queue; entries are reserved for every step in flight
  logic [1:0]         fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, occupied;

  assign out_valid_o  = (cnt_q != '0);
  assign pop          = out_valid_o && out_ready_i;
  assign edge_res_o   = fifo_mem[rd_ptr_q][0];
  assign frame_last_o = fifo_mem[rd_ptr_q][1];

  assign occupied = cnt_q + CNT_W'(s1_v_q) + CNT_W'(s2_v_q) + CNT_W'(s3_v_q)
                  + CNT_W'(s4_v_q) + CNT_W'(s5_v_q);
  assign in_ready_o = (occupied < CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= {s5_qinfo_q.last, wide};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/lemd_checker.sv =====
module lemd_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic edge_res_o,
  input logic frame_last_o
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(edge_res_o) && $stable(frame_last_o))
    else $error("result changed while stalled");

  // nothing to deliver straight after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

  // a result appearing on an empty output comes from an earlier input transaction
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 6))
    else $error("result without matching input transaction");

  // input back-pressure only when results are waiting
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind laplacian_edge_mask_dilate lemd_sva u_lemd_sva (.*);

// ===== sim/lemd_checker.sv =====
module lemd_checker
  import lemd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_CH_W-1:0]    red_i,
  input  logic [IN_CH_W-1:0]    green_i,
  input  logic [IN_CH_W-1:0]    blue_i,
  input  logic                  filler_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  edge_res_i,
  input  logic                  frame_last_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned HIST = 4 * MAX_LINE;

  typedef struct packed {
    logic edge_mark;
    logic frame_end;
  } mark_t;

  mark_t             marks_due[$];
  pix_t              pixel_hist [HIST];
  logic              edge_hist  [HIST];
  logic [THR_W-1:0]  thr_q;
  logic [LLEN_W-1:0] llen_q;
  logic [LCNT_W-1:0] lcnt_q;
  int unsigned       pix_in, res_out;

  function automatic int unsigned hslot(int unsigned r, int unsigned c, int unsigned len);
    return (r * len + c) % HIST;
  endfunction

  // laplacian of one pixel, largest channel against the threshold
  function automatic logic laplace_mark(int unsigned a, int unsigned b, int unsigned len,
                                        int unsigned n);
    int unsigned m, cnt, ctr;
    int unsigned nb [4];
    longint      lim, best, s;
    logic        vb, hb;
    m    = len - 1;
    ctr  = hslot(a, b, len);
    lim  = longint'(thr_q);
    best = -(longint'(1) <<< 62);
    vb   = (a == 0 || a == n);
    hb   = (b == 0 || b == m);
    if (vb && hb) begin
      nb[0] = hslot(a, (b == 0) ? 1 : m - 1, len);
      nb[1] = hslot((a == 0) ? 1 : n - 1, b, len);
      cnt = 2;
    end else if (vb) begin
      nb[0] = hslot(a, b - 1, len);
      nb[1] = hslot(a, b + 1, len);
      cnt = 2;
    end else if (hb) begin
      nb[0] = hslot(a - 1, b, len);
      nb[1] = hslot(a + 1, b, len);
      cnt = 2;
    end else begin
      nb[0] = hslot(a - 1, b, len);
      nb[1] = hslot(a + 1, b, len);
      nb[2] = hslot(a, b - 1, len);
      nb[3] = hslot(a, b + 1, len);
      cnt = 4;
      lim = lim * 2;
    end
    for (int ch = 0; ch < 3; ch++) begin
      s = -longint'(cnt) * longint'(pixel_hist[ctr][ch]);
      for (int k = 0; k < cnt; k++) s += longint'(pixel_hist[nb[k]][ch]);
      if (s > best) best = s;
    end
    return best > lim;
  endfunction

  function automatic logic dilated_mark(int unsigned q, int unsigned len, int unsigned n);
    int unsigned i, j;
    i = q / len;
    j = q % len;
    if (i == 0 || i == n || j == 0 || j == len - 1) return edge_hist[q % HIST];
    for (int di = 0; di < 3; di++)
      for (int dj = 0; dj < 3; dj++)
        if (edge_hist[hslot(i + di - 1, j + dj - 1, len)]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void take_pixel(pix_t px, logic fill);
    int unsigned len, lines, total, delay, t, e, q;
    mark_t mk;
    len   = (llen_q < 3) ? 3 : (llen_q > MAX_LINE) ? MAX_LINE : llen_q;
    lines = (lcnt_q < 3) ? 3 : lcnt_q;
    total = len * lines;
    delay = 2 * len + 2;
    if (pix_in < total) begin
      if (fill) return;
      t = pix_in;
      pixel_hist[t % HIST] = px;
      pix_in++;
    end else begin
      t = res_out + delay;
    end
    if (t >= len + 1) begin
      e = t - len - 1;
      if (e < total) edge_hist[e % HIST] = laplace_mark(e / len, e % len, len, lines - 1);
    end
    if (t >= delay) begin
      q = t - delay;
      mk.edge_mark = dilated_mark(q, len, lines - 1);
      mk.frame_end = (q == total - 1);
      marks_due.push_back(mk);
      res_out++;
      if (mk.frame_end) begin
        pix_in  = 0;
        res_out = 0;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mark_t exp_mk;
    pix_t  px;
    if (!rst_ni) begin
      thr_q        = 16'd205;
      llen_q       = 11'd1024;
      lcnt_q       = 16'd1024;
      pix_in       = 0;
      res_out      = 0;
      fail_count_o = 0;
      marks_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (marks_due.size() == 0) begin
          $display("%0t: unexpected result edge_res=%0b frame_last=%0b",
                   $time, edge_res_i, frame_last_i);
          fail_count_o++;
        end else begin
          exp_mk = marks_due.pop_front();
          if (edge_res_i !== exp_mk.edge_mark) begin
            $display("%0t: edge_res expected %0b actual %0b",
                     $time, exp_mk.edge_mark, edge_res_i);
            fail_count_o++;
          end
          if (frame_last_i !== exp_mk.frame_end) begin
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, exp_mk.frame_end, frame_last_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_EDGE_THRESHOLD: thr_q  = cfg_wdata_i[THR_W-1:0];
          REG_LINE_LENGTH:    llen_q = cfg_wdata_i[LLEN_W-1:0];
          REG_LINE_COUNT:     lcnt_q = cfg_wdata_i[LCNT_W-1:0];
          default: ;
        endcase
        if (cfg_index_i inside {REG_EDGE_THRESHOLD, REG_LINE_LENGTH, REG_LINE_COUNT}) begin
          pix_in  = 0;
          res_out = 0;
        end
      end
      if (in_valid_i && in_ready_i) begin
        px[0] = red_i[CHANNEL_BITS-1:0];
        px[1] = green_i[CHANNEL_BITS-1:0];
        px[2] = blue_i[CHANNEL_BITS-1:0];
        take_pixel(px, filler_i);
      end
    end
    pending_o = marks_due.size();
  end

endmodule

// ===== sim/laplacian_edge_mask_dilate_tb.sv =====
module laplacian_edge_mask_dilate_tb;
  import lemd_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [IN_CH_W-1:0]    red_i = '0, green_i = '0, blue_i = '0;
  logic                  filler_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  edge_res_o, frame_last_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_EDGE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int fail_count, pending;

  // stimulus knobs shared with the receiver
  bit gaps_on = 1'b1;     // random idling on both sides
  bit stall_req = 1'b0;   // ask the receiver for one long hold-off
  bit stall_taken = 1'b0;
  int hold_left = 0;
  int pix_style = 0;      // 0 mixed content, 1 only full-scale extremes
  logic [15:0] base_lvl = 16'h1000;
  int items_sent = 0, frames_done = 0, cut_frames = 0;

  laplacian_edge_mask_dilate dut (.*);

  lemd_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .red_i, .green_i,
    .blue_i, .filler_i, .out_valid_i(out_valid_o), .out_ready_i, .edge_res_i(edge_res_o),
    .frame_last_i(frame_last_o), .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // generous ceiling: biggest frame plus all random frames with stalls, many times over
  initial begin
    #4_000_000;
    $display("timeout with %0d results still due", pending);
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off counted here
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        hold_left   = 150;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = gaps_on ? ($urandom_range(99) >= 31) : 1'b1;
      end
    end
  end

  function automatic logic [15:0] pick_chan();
    if (pix_style == 1) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return base_lvl + 16'($urandom_range(0, 600)) - 16'd300;
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return base_lvl;
    endcase
  endfunction

  // one input transaction; valid stays up afterwards unless the caller drops it
  task automatic send_item(input logic fill);
    if (gaps_on && $urandom_range(99) < 31) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    red_i      = pick_chan();
    green_i    = pick_chan();
    blue_i     = pick_chan();
    filler_i   = fill;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (!fill) items_sent++;
  endtask

  // sender stops until every result is back, then lets the pipeline settle
  task automatic wait_settled();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // whole frame with interleaved ignored fillers and a drain tail;
  // cut_at >= 0 abandons the frame after that many pixels
  task automatic run_frame(input logic [15:0] thr, input logic [15:0] len,
                           input logic [15:0] cnt, input int cut_at);
    int unsigned le, lc;
    write_reg(REG_EDGE_THRESHOLD, thr);
    write_reg(REG_LINE_LENGTH, len);
    write_reg(REG_LINE_COUNT, cnt);
    le = (len < 3) ? 3 : (len > MAX_LINE) ? MAX_LINE : len;
    lc = (cnt < 3) ? 3 : cnt;
    base_lvl = 16'($urandom);
    for (int unsigned p = 0; p < le * lc; p++) begin
      if (cut_at >= 0 && p == cut_at) begin
        cut_frames++;
        wait_settled();
        return;
      end
      // a filler before the frame is complete gets no result
      if ($urandom_range(99) < 5) send_item(1'b1);
      send_item(1'b0);
    end
    // drain: real pixels here count as fillers
    for (int unsigned d = 0; d < 2 * le + 2; d++) send_item(logic'($urandom_range(1)));
    frames_done++;
    wait_settled();
  endtask

  initial begin
    int k;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: smallest frame, zero threshold, full-scale pixels
    pix_style = 1;
    run_frame(16'd0, 16'd3, 16'd3, -1);
    pix_style = 0;
    // largest line and frame height, abandoned by the next register write
    run_frame(16'hFFFF, 16'd1024, 16'hFFFF, 12);

    // random frames, clamped sizes included
    k = 0;
    while (items_sent < 550) begin
      logic [15:0] thr, len, cnt;
      case ($urandom_range(4))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'd205;
        3: thr = 16'($urandom_range(0, 4096));
        default: thr = 16'($urandom);
      endcase
      len = 16'($urandom_range(0, 10));
      cnt = 16'($urandom_range(0, 6));
      gaps_on = !(k == 4 || k == 5);
      if (k == 2) begin
        len = 16'd8;
        cnt = 16'd6;
        stall_req = 1'b1;
      end
      run_frame(thr, len, cnt, -1);
      k++;
    end

    // line length written past the top of the range, abandoned early
    gaps_on = 1'b1;
    run_frame(16'($urandom_range(0, 2048)), 16'd2047, 16'd3, 20);

    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    $display("%0d pixels over %0d full frames and %0d abandoned frames",
             items_sent, frames_done, cut_frames);
    $display("full frames from clamped 3x3 up to 10 wide, full-width lines only abandoned");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
